FILE: rtl/i2cm_pkg.sv
// Package: command codes, sequencer state and result types for the I2C bit-level master.
package i2cm_pkg;

    localparam int TPU_W = 10;
    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(72);

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [2:0]       active_command;
        logic [3:0]       bit_index;
        logic [2:0]       segment_index;
        logic [2:0]       unit_counter;
        logic [TPU_W-1:0] prescale_counter;
        logic [7:0]       shift_register;
        logic             ack_flag;
        logic             scl_level;
        logic             sda_level;
        logic             ack_choice;
        logic [7:0]       last_read;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        active_command:   CMD_NONE,
        bit_index:        4'd0,
        segment_index:    3'd0,
        unit_counter:     3'd0,
        prescale_counter: '0,
        shift_register:   8'd0,
        ack_flag:         1'b0,
        scl_level:        1'b1,
        sda_level:        1'b1,
        ack_choice:       1'b0,
        last_read:        8'd0
    };

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } seq_result_t;

endpackage

FILE: rtl/i2cm_if.sv
// Interfaces: command input channel, result output channel and configuration write channel.
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, command, data_byte, send_ack, sda_in, input ready);
    modport sink (input valid, command, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;

    modport source (output valid, scl_release, sda_release, busy_res, done_res, read_byte,
                    ack_seen, input ready);
    modport sink (input valid, scl_release, sda_release, busy_res, done_res, read_byte,
                  ack_seen, output ready);
endinterface

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/i2cm_step.sv
// Next-state and result logic for one tick of the I2C bit sequencer.
module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t       cur,
    input  logic [2:0]       command,
    input  logic [7:0]       data_byte,
    input  logic             send_ack,
    input  logic             sda_in,
    input  logic [TPU_W-1:0] ticks_per_unit,
    output seq_state_t       nxt,
    output seq_result_t      res
);

    seq_state_t       s;
    logic [TPU_W-1:0] tpu;
    logic [TPU_W:0]   pre_inc;
    logic [3:0]       unit_inc;
    logic [3:0]       seg_inc;
    logic [4:0]       bit_inc;
    logic [2:0]       units;
    logic [2:0]       seg_cnt;
    logic [3:0]       grp_cnt;
    logic             busy;
    logic             done;
    logic             grp_bits;
    logic             grp_read_bits;

    always_comb
    begin
        s = cur;
        busy = 1'b0;
        done = 1'b0;
        tpu = (ticks_per_unit == '0) ? TPU_W'(1) : ticks_per_unit;

        if (cur.active_command == CMD_NONE &&
            (command == CMD_START || command == CMD_STOP ||
             command == CMD_WRITE || command == CMD_READ))
        begin
            s.active_command = command;
            s.bit_index = 4'd0;
            s.segment_index = 3'd0;
            s.unit_counter = 3'd0;
            s.prescale_counter = '0;
            if (command == CMD_WRITE)
            begin
                s.shift_register = data_byte;
            end
            if (command == CMD_READ)
            begin
                s.shift_register = 8'd0;
                s.ack_choice = send_ack;
            end
        end

        grp_bits = (s.bit_index < 4'd8);
        grp_read_bits = (s.bit_index != 4'd0) && (s.bit_index <= 4'd8);

        case (s.active_command)
            CMD_WRITE:
            begin
                grp_cnt = 4'd9;
                seg_cnt = grp_bits ? 3'd3 : 3'd4;
                if (grp_bits)
                begin
                    case (s.segment_index)
                        3'd0:    units = 3'd3;
                        3'd1:    units = 3'd5;
                        default: units = 3'd2;
                    endcase
                end
                else
                begin
                    case (s.segment_index)
                        3'd0, 3'd1: units = 3'd3;
                        3'd2:       units = 3'd2;
                        default:    units = 3'd5;
                    endcase
                end
            end
            CMD_READ:
            begin
                grp_cnt = 4'd10;
                seg_cnt = (s.bit_index == 4'd0) ? 3'd1 : 3'd3;
                if (s.bit_index == 4'd0)
                begin
                    units = 3'd3;
                end
                else if (grp_read_bits)
                begin
                    case (s.segment_index)
                        3'd0:    units = 3'd3;
                        3'd1:    units = 3'd2;
                        default: units = 3'd5;
                    endcase
                end
                else
                begin
                    units = (s.segment_index == 3'd0) ? 3'd3 : 3'd5;
                end
            end
            CMD_START:
            begin
                grp_cnt = 4'd1;
                seg_cnt = 3'd4;
                units = 3'd3;
            end
            default:
            begin
                grp_cnt = 4'd1;
                seg_cnt = 3'd3;
                units = 3'd3;
            end
        endcase

        pre_inc = {1'b0, s.prescale_counter} + (TPU_W+1)'(1);
        unit_inc = {1'b0, s.unit_counter} + 4'd1;
        seg_inc = {1'b0, s.segment_index} + 4'd1;
        bit_inc = {1'b0, s.bit_index} + 5'd1;

        if (s.active_command != CMD_NONE)
        begin
            busy = 1'b1;
            if (s.prescale_counter == '0 && s.unit_counter == 3'd0)
            begin
                case (s.active_command)
                    CMD_START:
                    begin
                        case (s.segment_index)
                            3'd0:    s.scl_level = 1'b1;
                            3'd1:    s.sda_level = 1'b1;
                            3'd2:    s.sda_level = 1'b0;
                            default: s.scl_level = 1'b0;
                        endcase
                    end
                    CMD_STOP:
                    begin
                        case (s.segment_index)
                            3'd0:    s.sda_level = 1'b0;
                            3'd1:    s.scl_level = 1'b1;
                            default: s.sda_level = 1'b1;
                        endcase
                    end
                    CMD_WRITE:
                    begin
                        if (grp_bits)
                        begin
                            case (s.segment_index)
                                3'd0:    s.sda_level = s.shift_register[3'd7 - s.bit_index[2:0]];
                                3'd1:    s.scl_level = 1'b1;
                                default: s.scl_level = 1'b0;
                            endcase
                        end
                        else
                        begin
                            case (s.segment_index)
                                3'd0:    s.sda_level = 1'b1;
                                3'd1:    s.scl_level = 1'b1;
                                3'd2:    s.ack_flag = ~sda_in;
                                default: s.scl_level = 1'b0;
                            endcase
                        end
                    end
                    default:
                    begin
                        if (s.bit_index == 4'd0)
                        begin
                            s.sda_level = 1'b1;
                        end
                        else if (grp_read_bits)
                        begin
                            case (s.segment_index)
                                3'd0:
                                begin
                                    s.shift_register = {s.shift_register[6:0], 1'b0};
                                    s.scl_level = 1'b1;
                                end
                                3'd1:    s.shift_register[0] = s.shift_register[0] | sda_in;
                                default: s.scl_level = 1'b0;
                            endcase
                        end
                        else
                        begin
                            case (s.segment_index)
                                3'd0:    s.sda_level = ~s.ack_choice;
                                3'd1:    s.scl_level = 1'b1;
                                default: s.scl_level = 1'b0;
                            endcase
                        end
                    end
                endcase
            end

            s.prescale_counter = pre_inc[TPU_W-1:0];
            if (pre_inc >= {1'b0, tpu})
            begin
                s.prescale_counter = '0;
                s.unit_counter = unit_inc[2:0];
                if (unit_inc >= {1'b0, units})
                begin
                    s.unit_counter = 3'd0;
                    s.segment_index = seg_inc[2:0];
                    if (seg_inc >= {1'b0, seg_cnt})
                    begin
                        s.segment_index = 3'd0;
                        s.bit_index = bit_inc[3:0];
                        if (bit_inc >= {1'b0, grp_cnt})
                        begin
                            s.bit_index = 4'd0;
                            done = 1'b1;
                            if (s.active_command == CMD_READ)
                            begin
                                s.last_read = s.shift_register;
                            end
                            s.active_command = CMD_NONE;
                        end
                    end
                end
            end
        end

        nxt = s;
        res.scl_release = s.scl_level;
        res.sda_release = s.sda_level;
        res.busy_res = busy;
        res.done_res = done;
        res.read_byte = s.last_read;
        res.ack_seen = s.ack_flag;
    end

endmodule

FILE: rtl/i2c_bit_level_master.sv
// Top level: I2C bit-level master with sequencer state, result register and configuration.
// One item is one tick of the bit timer: the block takes an item in every cycle and
// returns its result in the next cycle from a single result register, so the sustained
// rate is one item per cycle whenever the result side keeps taking. A stalled result
// holds the input side until it is taken. Each timing segment spans 3, 5 or 2 units of
// ticks_per_unit items (a value of zero counts as one); commands arriving while a
// sequence runs are dropped. The configuration write is always ready.
module i2c_bit_level_master
    import i2cm_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    i2cm_req_if.sink    req,
    i2cm_rsp_if.source  rsp,
    i2cm_cfg_if.sink    cfg
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    seq_result_t      rsp_reg;
    seq_result_t      rsp_next;
    logic             rsp_valid_reg;
    logic [TPU_W-1:0] tpu_reg;
    logic             accept;

    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept = req.valid & req.ready;
    assign cfg.ready = 1'b1;

    i2cm_step u_step (
        .cur            (state_reg),
        .command        (req.command),
        .data_byte      (req.data_byte),
        .send_ack       (req.send_ack),
        .sda_in         (req.sda_in),
        .ticks_per_unit (tpu_reg),
        .nxt            (state_next),
        .res            (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_STATE_RESET;
            rsp_valid_reg <= 1'b0;
            tpu_reg <= TPU_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                tpu_reg <= cfg.data;
            end
            if (accept)
            begin
                state_reg <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.scl_release = rsp_reg.scl_release;
    assign rsp.sda_release = rsp_reg.sda_release;
    assign rsp.busy_res = rsp_reg.busy_res;
    assign rsp.done_res = rsp_reg.done_res;
    assign rsp.read_byte = rsp_reg.read_byte;
    assign rsp.ack_seen = rsp_reg.ack_seen;

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.done_res) |-> rsp_reg.busy_res)
        else $error("done without busy");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.active_command == CMD_NONE) |->
        (state_reg.bit_index == 4'd0 && state_reg.segment_index == 3'd0 &&
         state_reg.unit_counter == 3'd0 && state_reg.prescale_counter == '0))
        else $error("idle sequencer with stale counters");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> $stable(state_reg))
        else $error("sequencer advanced while result stalled");
`endif

endmodule
